/* hw/rtl/ipd_pkg.sv */
// Shared widths, register indexes and constants for the impact peak detector.
// No dependencies; imported by the detector and its port checker.
package ipd_pkg;

	localparam int unsigned RAW_W   = 24;
	localparam int unsigned FORCE_W = 24;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned SCALE_W = 32;
	localparam int unsigned PCT_W   = 16;
	localparam int unsigned LVL_W   = 4;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// serial multiplier: magnitude bits times scale
	localparam int unsigned PROD_W = FORCE_W + SCALE_W;
	localparam int unsigned FRAC_W = 16;
	// serial divider: peak times one hundred
	localparam int unsigned DIVD_W = FORCE_W + 7;

	localparam logic signed [RAW_W-1:0] RAIL_HIGH = 24'sh7EFF00;
	localparam logic signed [RAW_W-1:0] RAIL_LOW  = -24'sd8388600;
	localparam logic [FORCE_W-1:0] FORCE_MAX  = 24'hFFFFFF;
	localparam logic [PCT_W-1:0]   PCT_MAX    = 16'hFFFF;
	localparam logic [DIVD_W-1:0]  PCT_SCALE  = 31'd100;
	localparam logic [PCT_W-1:0]   LVL_STEP   = 16'd10;
	localparam logic [LVL_W-1:0]   LVL_MAX    = 4'd10;
	localparam logic [PCT_W-1:0]   LVL_TOP_PCT = 16'd90;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARE_OFFSET   = 3'd0,
		REG_INV_SCALE     = 3'd1,
		REG_MIN_RISE      = 3'd2,
		REG_TRIGGER_LEVEL = 3'd3,
		REG_LOCKOUT_MS    = 3'd4,
		REG_WINDOW_MS     = 3'd5,
		REG_FULL_SCALE    = 3'd6
	} cfg_reg_t;

	localparam logic [SCALE_W-1:0] INV_SCALE_RST  = 32'd65536;
	localparam logic [TIME_W-1:0]  LOCKOUT_RST    = 32'd1000;
	localparam logic [TIME_W-1:0]  WINDOW_RST     = 32'd200;
	localparam logic [FORCE_W-1:0] FULL_SCALE_RST = 24'd1;

endpackage

/* hw/rtl/impact_peak_detector.sv */
// Impact peak detector top level: sample screening, serial force scaling,
// strike trigger and peak hold, serial percent divide. Depends on ipd_pkg.
//
// One load-cell sample is taken per transaction and exactly one result is
// returned for it. A timeout or rail reading goes straight to the emit state,
// and the next sample can be taken once its result has been handed to the
// output register. Any other sample is scaled by a bit-serial shift-add
// multiplier and then judged in the decide state before it is emitted. A
// sample that closes a strike window also runs a bit-serial restoring divider
// for the percent of full scale, and the emit state latches the saturated
// quotient before the result is sent (no latch step when the percent is zero).
// The result sits in an output register, so a new sample is taken while an
// earlier result still waits for out_ready. A second result then holds the
// input until the first is taken.
// Configuration writes are always ready and act at once, so write them only
// while no sample is in flight.
module impact_peak_detector
	import ipd_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [RAW_W-1:0]      raw_sample,
	input  logic                         read_timeout,
	input  logic [TIME_W-1:0]            now_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         strike_done,
	output logic [FORCE_W-1:0]           peak_value,
	output logic [PCT_W-1:0]             peak_percent,
	output logic [LVL_W-1:0]             peak_level,
	output logic                         sample_rejected
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DECIDE,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;
	logic [4:0] cnt_q;

	logic signed [RAW_W-1:0] tare_q;
	logic [SCALE_W-1:0] inv_scale_q;
	logic [FORCE_W-1:0] min_rise_q;
	logic [FORCE_W-1:0] trig_level_q;
	logic [TIME_W-1:0]  lockout_q;
	logic [TIME_W-1:0]  window_q;
	logic [FORCE_W-1:0] full_scale_q;

	logic               measuring_q;
	logic [TIME_W-1:0]  window_start_q;
	logic [FORCE_W-1:0] held_peak_q;
	logic [FORCE_W-1:0] prev_force_q;
	logic [TIME_W-1:0]  last_strike_q;

	logic [TIME_W-1:0]  now_q;
	logic [PROD_W-1:0]  prod_q;
	logic [FORCE_W:0]   rem_q;
	logic [DIVD_W-1:0]  quo_q;

	logic               res_done_q;
	logic               res_rej_q;
	logic [FORCE_W-1:0] res_peak_q;
	logic [PCT_W-1:0]   res_pct_q;

	logic               out_valid_q;
	logic               out_done_q;
	logic               out_rej_q;
	logic [FORCE_W-1:0] out_peak_q;
	logic [PCT_W-1:0]   out_pct_q;
	logic [LVL_W-1:0]   out_lvl_q;

	logic                    rejected;
	logic signed [RAW_W:0]   diff;
	logic [RAW_W-1:0]        mag;
	logic [SCALE_W:0]        mul_sum;
	logic [FORCE_W-1:0]      force_val;
	logic                    rise_ok;
	logic                    trig_ok;
	logic                    lock_ok;
	logic                    win_ok;
	logic [FORCE_W-1:0]      new_peak;
	logic [FORCE_W:0]        div_shift;
	logic [FORCE_W:0]        div_sub;
	logic                    div_bit;
	logic [FORCE_W-1:0]      fs_eff;
	logic [PCT_W-1:0]        pct_sat;
	logic [LVL_W-1:0]        level;
	logic                    emit_go;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	assign rejected = read_timeout || (raw_sample >= RAIL_HIGH) || (raw_sample <= RAIL_LOW);
	assign diff = {raw_sample[RAW_W-1], raw_sample} - {tare_q[RAW_W-1], tare_q};
	assign mag  = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];

	assign mul_sum = {1'b0, prod_q[PROD_W-1:RAW_W]} + (prod_q[0] ? {1'b0, inv_scale_q} :
		{(SCALE_W+1){1'b0}});

	assign force_val = (|prod_q[PROD_W-1:FRAC_W+FORCE_W]) ? FORCE_MAX :
		prod_q[FRAC_W+FORCE_W-1:FRAC_W];
	assign rise_ok = {1'b0, force_val} >= ({1'b0, prev_force_q} + {1'b0, min_rise_q});
	assign trig_ok = force_val >= trig_level_q;
	assign lock_ok = (now_q - last_strike_q) >= lockout_q;
	assign win_ok  = (now_q - window_start_q) >= window_q;
	assign new_peak = (force_val > held_peak_q) ? force_val : held_peak_q;

	assign fs_eff    = (full_scale_q == '0) ? FORCE_W'(1) : full_scale_q;
	assign div_shift = {rem_q[FORCE_W-1:0], quo_q[DIVD_W-1]};
	assign div_sub   = div_shift - {1'b0, fs_eff};
	assign div_bit   = div_shift >= {1'b0, fs_eff};
	assign pct_sat   = (|quo_q[DIVD_W-1:PCT_W]) ? PCT_MAX : quo_q[PCT_W-1:0];

	assign emit_go = (state_q == S_EMIT) && !(res_done_q && res_pct_q != pct_sat) &&
		(!out_valid_q || out_ready);

	always_comb begin
		level = '0;
		if (res_pct_q > LVL_TOP_PCT) begin
			level = LVL_MAX;
		end else begin
			for (int k = 0; k < 10; k++) begin
				if (res_pct_q > PCT_W'(k) * LVL_STEP) begin
					level = level + LVL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q       <= '0;
			inv_scale_q  <= INV_SCALE_RST;
			min_rise_q   <= '0;
			trig_level_q <= '0;
			lockout_q    <= LOCKOUT_RST;
			window_q     <= WINDOW_RST;
			full_scale_q <= FULL_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TARE_OFFSET:   tare_q       <= cfg_data[RAW_W-1:0];
				REG_INV_SCALE:     inv_scale_q  <= cfg_data[SCALE_W-1:0];
				REG_MIN_RISE:      min_rise_q   <= cfg_data[FORCE_W-1:0];
				REG_TRIGGER_LEVEL: trig_level_q <= cfg_data[FORCE_W-1:0];
				REG_LOCKOUT_MS:    lockout_q    <= cfg_data[TIME_W-1:0];
				REG_WINDOW_MS:     window_q     <= cfg_data[TIME_W-1:0];
				REG_FULL_SCALE:    full_scale_q <= cfg_data[FORCE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			measuring_q    <= 1'b0;
			window_start_q <= '0;
			held_peak_q    <= '0;
			prev_force_q   <= '0;
			last_strike_q  <= '0;
			now_q          <= '0;
			prod_q         <= '0;
			rem_q          <= '0;
			quo_q          <= '0;
			res_done_q     <= 1'b0;
			res_rej_q      <= 1'b0;
			res_peak_q     <= '0;
			res_pct_q      <= '0;
			out_valid_q    <= 1'b0;
			out_done_q     <= 1'b0;
			out_rej_q      <= 1'b0;
			out_peak_q     <= '0;
			out_pct_q      <= '0;
			out_lvl_q      <= '0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						now_q      <= now_ms;
						res_rej_q  <= rejected;
						res_done_q <= 1'b0;
						res_peak_q <= '0;
						res_pct_q  <= '0;
						if (rejected) begin
							prev_force_q <= '0;
							state_q      <= S_EMIT;
						end else begin
							prod_q  <= {{SCALE_W{1'b0}}, mag};
							cnt_q   <= 5'(RAW_W - 1);
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					prod_q <= {mul_sum, prod_q[RAW_W-1:1]};
					cnt_q  <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					prev_force_q <= force_val;
					state_q      <= S_EMIT;
					if (!measuring_q) begin
						if (rise_ok && trig_ok && lock_ok) begin
							measuring_q    <= 1'b1;
							window_start_q <= now_q;
							held_peak_q    <= force_val;
						end
					end else begin
						held_peak_q <= new_peak;
						if (win_ok) begin
							measuring_q   <= 1'b0;
							last_strike_q <= now_q;
							res_done_q    <= 1'b1;
							res_peak_q    <= new_peak;
							rem_q         <= '0;
							quo_q         <= {7'd0, new_peak} * PCT_SCALE;
							cnt_q         <= 5'(DIVD_W - 1);
							state_q       <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q <= div_bit ? div_sub : div_shift;
					quo_q <= {quo_q[DIVD_W-2:0], div_bit};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_done_q && res_pct_q != pct_sat) begin
						res_pct_q <= pct_sat;
					end else if (emit_go) begin
						out_done_q  <= res_done_q;
						out_rej_q   <= res_rej_q;
						out_peak_q  <= res_peak_q;
						out_pct_q   <= res_pct_q;
						out_lvl_q   <= res_done_q ? level : '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign strike_done     = out_done_q;
	assign sample_rejected = out_rej_q;
	assign peak_value      = out_peak_q;
	assign peak_percent    = out_pct_q;
	assign peak_level      = out_lvl_q;

endmodule

/* hw/rtl/impact_peak_detector_chk.sv */
// Port-level checker for the impact peak detector and its bind statement.
// Depends on ipd_pkg and the detector's port list.
module impact_peak_detector_chk
	import ipd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               strike_done,
	input logic [FORCE_W-1:0] peak_value,
	input logic [PCT_W-1:0]   peak_percent,
	input logic [LVL_W-1:0]   peak_level,
	input logic               sample_rejected
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(peak_value) &&
		$stable(peak_percent) && $stable(peak_level) && $stable(strike_done))
		else $error("result transaction changed while stalled");

	a_done_not_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(strike_done && sample_rejected))
		else $error("rejected sample reported a strike");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !strike_done |-> peak_value == '0 && peak_percent == '0 &&
		peak_level == '0)
		else $error("peak fields nonzero without a strike");

	a_level_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && strike_done |-> (peak_level == LVL_MAX) == (peak_percent > LVL_TOP_PCT))
		else $error("peak level disagrees with percent");

	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && strike_done |-> (peak_level == '0) == (peak_percent == '0))
		else $error("zero level disagrees with percent");

endmodule

bind impact_peak_detector impact_peak_detector_chk u_chk (.*);
